// ----- hw/rtl/bsrx_pkg.sv -----
// Shared types and constants for the bisync reply frame receiver.
// No dependencies; imported by bsrx_step and the top level.
`timescale 1ns / 1ps

package bsrx_pkg;

  // Link control characters
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;

  // Default buffer size: STX + body + ETX + BCC
  localparam int MAX_FRAME_BYTES_DEF = 32;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 6;

  // Item modes; the spare code acts as force idle
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_ARM   = 2'd1;
  localparam logic [1:0] MODE_IDLE  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WSTX = 2'd1,
    PH_BODY = 2'd2,
    PH_WBCC = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY  = 3'd0,
    ST_OK    = 3'd1,
    ST_EOT   = 3'd2,
    ST_NOSTX = 3'd3,
    ST_BCC   = 3'd4,
    ST_LONG  = 3'd5,
    ST_NARM  = 3'd6
  } status_t;

  // Receiver state carried from item to item
  typedef struct packed {
    phase_t              phase;
    logic [BYTE_W-1:0]   check;
    logic [COUNT_W-1:0]  count;
  } rx_state_t;

  // One result item
  typedef struct packed {
    logic               payload_valid;
    logic [BYTE_W-1:0]  payload_byte;
    logic               frame_end;
    status_t            status;
    logic [BYTE_W-1:0]  computed_check;
  } rx_result_t;

endpackage

// ----- hw/rtl/bisync_reply_frame_receiver_top.sv -----
// Channel  | ports                                         | direction
// input    | in_valid, in_stall, in_mode, in_rx_byte        | byte or command in
// result   | out_valid, out_stall, out_payload_valid,       | one result per item
//          | out_payload_byte, out_frame_end, out_status,   |
//          | out_computed_check                            |
// Each item passes the input register, then is decoded into the result
// register; one item per cycle is sustained while out_stall is low, since the
// state loop is one compare and one XOR. Synchronous active-low reset empties
// both registers and returns the receiver to idle. While out_stall holds the
// result, one more item is taken into the input register, then in_stall rises.
// Top level of the bisync reply frame receiver; depends on bsrx_pkg, bsrx_step.
`timescale 1ns / 1ps

module bisync_reply_frame_receiver_top #(
  parameter int MAX_FRAME_BYTES = bsrx_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_end,
  output logic [2:0] out_status,
  output logic [7:0] out_computed_check
);
  import bsrx_pkg::*;

  localparam logic [COUNT_W-1:0] BodyLimit = COUNT_W'(MAX_FRAME_BYTES - 3);

  logic              s1_valid_r;
  logic [1:0]        s1_mode_r;
  logic [7:0]        s1_byte_r;
  rx_state_t         state_r;
  rx_state_t         state_nxt;
  rx_result_t        res_nxt;
  rx_result_t        res_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_xfer;

  // Result register free, or emptied by a transfer this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_rx_byte;
    end
  end

  bsrx_step #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_step (
    .mode      (s1_mode_r),
    .rx_byte   (s1_byte_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // Commit state as the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= PH_IDLE;
      state_r.check <= '0;
      state_r.count <= '0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_valid  = res_r.payload_valid;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_frame_end      = res_r.frame_end;
  assign out_status         = res_r.status;
  assign out_computed_check = res_r.computed_check;

  // Body count never passes the buffer limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count <= BodyLimit)
    else $error("body count beyond buffer limit");

  // A passed-out body byte never ends a frame
  a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.payload_valid) |-> (!res_r.frame_end && res_r.status == ST_BUSY))
    else $error("payload byte with frame end");

  // Frame end and a non-busy status go together
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.frame_end == (res_r.status != ST_BUSY)))
    else $error("frame end and status disagree");

  // Force idle clears the receiver
  a_force_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && (s1_mode_r == MODE_IDLE || s1_mode_r == MODE_SPARE))
    |=> (state_r.phase == PH_IDLE && state_r.check == '0 && state_r.count == '0))
    else $error("force idle did not clear state");

  // Input stalls only with an item held in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room to spare");

endmodule

// ----- hw/rtl/bsrx_step.sv -----
// Per-byte frame decode: next receiver state and the result for one item.
// Pure combinational logic; depends on bsrx_pkg.
`timescale 1ns / 1ps

module bsrx_step #(
  parameter int MAX_FRAME_BYTES = bsrx_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic [1:0]             mode,
  input  logic [7:0]             rx_byte,
  input  bsrx_pkg::rx_state_t    state_cur,
  output bsrx_pkg::rx_state_t    state_nxt,
  output bsrx_pkg::rx_result_t   result
);
  import bsrx_pkg::*;

  // Largest body that fits the buffer
  localparam logic [COUNT_W-1:0] BodyLimit = COUNT_W'(MAX_FRAME_BYTES - 3);

  logic body_full;
  assign body_full = (state_cur.count >= BodyLimit);

  // Decode one item against the current phase
  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    result.status = ST_BUSY;

    case (mode)
      MODE_ARM: begin
        state_nxt.phase = PH_WSTX;
        state_nxt.check = '0;
        state_nxt.count = '0;
      end
      MODE_BYTE: begin
        case (state_cur.phase)
          PH_WSTX: begin
            if (rx_byte == CH_STX) begin
              state_nxt.phase = PH_BODY;
              state_nxt.check = '0;
              state_nxt.count = '0;
            end else begin
              result.frame_end = 1'b1;
              result.status    = (rx_byte == CH_EOT) ? ST_EOT : ST_NOSTX;
              state_nxt.phase  = PH_IDLE;
            end
          end
          PH_BODY: begin
            if (rx_byte == CH_EOT) begin
              result.frame_end = 1'b1;
              result.status    = ST_EOT;
              state_nxt.phase  = PH_IDLE;
            end else if (rx_byte == CH_ETX) begin
              state_nxt.check = state_cur.check ^ rx_byte;
              state_nxt.phase = PH_WBCC;
            end else if (body_full) begin
              result.frame_end = 1'b1;
              result.status    = ST_LONG;
              state_nxt.phase  = PH_IDLE;
            end else begin
              state_nxt.check      = state_cur.check ^ rx_byte;
              state_nxt.count      = state_cur.count + COUNT_W'(1);
              result.payload_valid = 1'b1;
              result.payload_byte  = rx_byte;
            end
          end
          PH_WBCC: begin
            result.frame_end = 1'b1;
            if (rx_byte == state_cur.check) begin
              result.status   = ST_OK;
              state_nxt.phase = PH_WSTX;
            end else begin
              result.status   = ST_BCC;
              state_nxt.phase = PH_IDLE;
            end
          end
          default: begin
            // Byte with no enquiry outstanding
            result.frame_end = 1'b1;
            result.status    = ST_NARM;
          end
        endcase
      end
      default: begin
        // Force idle, also for the unused mode code
        state_nxt.phase = PH_IDLE;
        state_nxt.check = '0;
        state_nxt.count = '0;
      end
    endcase

    result.computed_check = state_nxt.check;
  end

endmodule

// ----- sim/bsrx_checker.sv -----
// Checker for the bisync reply frame receiver: watches both channels, predicts
// each result from its own receiver state and compares in order.
// Depends on bsrx_pkg for the control characters, modes, phases and statuses.
`timescale 1ns / 1ps

module bsrx_checker #(
  parameter int MAX_FRAME_BYTES = bsrx_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_payload_valid,
  input  logic [7:0] out_payload_byte,
  input  logic       out_frame_end,
  input  logic [2:0] out_status,
  input  logic [7:0] out_computed_check,
  output int         mismatch_count,
  output int         pending_replies
);
  import bsrx_pkg::*;

  // Body bytes that fit between STX and ETX + BCC
  localparam int BODY_LIMIT = MAX_FRAME_BYTES - 3;

  phase_t             rx_phase;
  logic [BYTE_W-1:0]  bcc_acc;
  logic [COUNT_W-1:0] body_len;
  rx_result_t         reply_q[$];
  int                 reply_idx;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] reply %0d mismatch: %s", $time, reply_idx, msg);
    mismatch_count++;
  endtask

  // Advance the receiver state by one item and form its reply
  task automatic predict_reply(input logic [1:0] mode, input logic [7:0] b,
                               output rx_result_t r);
    r = '0;
    r.status = ST_BUSY;
    if (mode == MODE_ARM) begin
      rx_phase = PH_WSTX;
      bcc_acc  = '0;
      body_len = '0;
    end else if (mode != MODE_BYTE) begin
      // force idle, and the unused mode code behaves the same
      rx_phase = PH_IDLE;
      bcc_acc  = '0;
      body_len = '0;
    end else begin
      case (rx_phase)
        PH_WSTX: begin
          if (b == CH_STX) begin
            rx_phase = PH_BODY;
            bcc_acc  = '0;
            body_len = '0;
          end else begin
            r.frame_end = 1'b1;
            r.status    = (b == CH_EOT) ? ST_EOT : ST_NOSTX;
            rx_phase    = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (b == CH_EOT) begin
            r.frame_end = 1'b1;
            r.status    = ST_EOT;
            rx_phase    = PH_IDLE;
          end else if (b == CH_ETX) begin
            bcc_acc  = bcc_acc ^ b;
            rx_phase = PH_WBCC;
          end else if (int'(body_len) + 1 > BODY_LIMIT) begin
            r.frame_end = 1'b1;
            r.status    = ST_LONG;
            rx_phase    = PH_IDLE;
          end else begin
            bcc_acc         = bcc_acc ^ b;
            body_len        = body_len + COUNT_W'(1);
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
          end
        end
        PH_WBCC: begin
          r.frame_end = 1'b1;
          if (b == bcc_acc) begin
            r.status = ST_OK;
            rx_phase = PH_WSTX;
          end else begin
            r.status = ST_BCC;
            rx_phase = PH_IDLE;
          end
        end
        default: begin
          // byte while unarmed: state is left alone
          r.frame_end = 1'b1;
          r.status    = ST_NARM;
        end
      endcase
    end
    r.computed_check = bcc_acc;
  endtask

  // Compare the result transfer first, then predict the input transfer
  always @(posedge clk) begin
    rx_result_t want;
    rx_result_t fresh;
    if (!rst_n) begin
      rx_phase = PH_IDLE;
      bcc_acc  = '0;
      body_len = '0;
      reply_q.delete();
      reply_idx = 0;
      mismatch_count = 0;
      pending_replies <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          flag_mismatch("result transfer with no item waiting");
        end else begin
          want = reply_q.pop_front();
          if (out_payload_valid !== want.payload_valid)
            flag_mismatch($sformatf("payload_valid got %0b want %0b",
                                    out_payload_valid, want.payload_valid));
          if (out_payload_byte !== want.payload_byte)
            flag_mismatch($sformatf("payload_byte got %02h want %02h",
                                    out_payload_byte, want.payload_byte));
          if (out_frame_end !== want.frame_end)
            flag_mismatch($sformatf("frame_end got %0b want %0b",
                                    out_frame_end, want.frame_end));
          if (out_status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d",
                                    out_status, want.status));
          if (out_computed_check !== want.computed_check)
            flag_mismatch($sformatf("computed_check got %02h want %02h",
                                    out_computed_check, want.computed_check));
        end
        reply_idx++;
      end
      if (in_valid && !in_stall) begin
        predict_reply(in_mode, in_rx_byte, fresh);
        reply_q.push_back(fresh);
      end
      pending_replies <= reply_q.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the bisync reply frame receiver: drives directed and random
// reply frames, stalls the result side and gives the verdict.
// Depends on bsrx_pkg, bisync_reply_frame_receiver_top and bsrx_checker.
`timescale 1ns / 1ps

module tb_top;
  import bsrx_pkg::*;

  localparam int BODY_LIMIT     = MAX_FRAME_BYTES_DEF - 3;
  localparam int RANDOM_ITEMS   = 900;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_mode;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_payload_valid;
  logic [7:0] out_payload_byte;
  logic       out_frame_end;
  logic [2:0] out_status;
  logic [7:0] out_computed_check;

  int mismatch_count;
  int pending_replies;
  int items_sent   = 0;
  int idle_cycles  = 0;
  bit no_idle      = 1'b0;
  bit armed        = 1'b0;

  bisync_reply_frame_receiver_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_frame_end      (out_frame_end),
    .out_status         (out_status),
    .out_computed_check (out_computed_check)
  );

  bsrx_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_valid  (out_payload_valid),
    .out_payload_byte   (out_payload_byte),
    .out_frame_end      (out_frame_end),
    .out_status         (out_status),
    .out_computed_check (out_computed_check),
    .mismatch_count     (mismatch_count),
    .pending_replies    (pending_replies)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: random stall bursts, none while no_idle is set
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      repeat ($urandom_range(1, 12)) @(negedge clk) out_stall <= 1'b0;
      if (!no_idle) repeat (pick_gap()) @(negedge clk) out_stall <= 1'b1;
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Present one item, hold it until the transfer
  task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Hold off the sender until every result has come back
  task automatic drain_replies();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_replies != 0) @(posedge clk);
  endtask

  // One reply frame, mostly well formed, with occasional breakage
  task automatic send_frame();
    int        len;
    int        abort_at;
    int        r;
    logic [7:0] b;
    logic [7:0] bcc;
    if (!armed || $urandom_range(0, 3) == 0) send_item(MODE_ARM, 8'($urandom));
    armed = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // wrong first byte: EOT or any non-STX byte
      b = 8'($urandom);
      if (b == CH_STX) b = 8'h82;
      send_item(MODE_BYTE, (r < 3) ? CH_EOT : b);
      armed = 1'b0;
      return;
    end
    send_item(MODE_BYTE, CH_STX);
    bcc = '0;
    r = $urandom_range(0, 99);
    if (r < 80)      len = $urandom_range(0, 8);
    else if (r < 94) len = $urandom_range(9, BODY_LIMIT - 2);
    else             len = $urandom_range(BODY_LIMIT - 1, BODY_LIMIT + 2);
    abort_at = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == abort_at) begin
        // abort mid-body with EOT, a re-arm or a forced idle
        r = $urandom_range(0, 2);
        if (r == 0) send_item(MODE_BYTE, CH_EOT);
        else if (r == 1) send_item(MODE_ARM, 8'($urandom));
        else send_item(MODE_IDLE, 8'($urandom));
        armed = (r == 1);
        return;
      end
      b = 8'($urandom);
      if (b == CH_ETX || b == CH_EOT) b = b ^ 8'h80;
      bcc = bcc ^ b;
      send_item(MODE_BYTE, b);
    end
    send_item(MODE_BYTE, CH_ETX);
    bcc = bcc ^ CH_ETX;
    if ($urandom_range(0, 99) < 10) begin
      send_item(MODE_BYTE, bcc ^ (8'h01 << $urandom_range(0, 7)));
      armed = 1'b0;
    end else begin
      send_item(MODE_BYTE, bcc);
      armed = (len <= BODY_LIMIT);
    end
  endtask

  initial begin
    int  limit;
    bit  drained;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_mode    <= MODE_BYTE;
    in_rx_byte <= 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bytes while unarmed, idle codes
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_IDLE, 8'h00);
    send_item(MODE_SPARE, 8'hFF);
    // good frame with extreme bytes and STX inside the body
    send_item(MODE_ARM, 8'h00);
    send_item(MODE_BYTE, CH_STX);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, CH_STX);
    send_item(MODE_BYTE, CH_ETX);
    send_item(MODE_BYTE, 8'hFF ^ 8'h00 ^ CH_STX ^ CH_ETX);
    // still armed: empty body, then a bad check
    send_item(MODE_BYTE, CH_STX);
    send_item(MODE_BYTE, CH_ETX);
    send_item(MODE_BYTE, 8'h00);
    // EOT and a stray byte in place of STX
    send_item(MODE_ARM, 8'hFF);
    send_item(MODE_BYTE, CH_EOT);
    send_item(MODE_ARM, 8'h00);
    send_item(MODE_BYTE, 8'h41);
    // EOT inside the body
    send_item(MODE_ARM, 8'h00);
    send_item(MODE_BYTE, CH_STX);
    send_item(MODE_BYTE, 8'h55);
    send_item(MODE_BYTE, CH_EOT);
    // re-arm and forced idle in the middle of a frame
    send_item(MODE_ARM, 8'h00);
    send_item(MODE_BYTE, CH_STX);
    send_item(MODE_BYTE, 8'h10);
    send_item(MODE_ARM, 8'h00);
    send_item(MODE_BYTE, CH_STX);
    send_item(MODE_IDLE, 8'hFF);
    armed = 1'b0;

    // Random frames with noise in between
    limit   = items_sent + RANDOM_ITEMS;
    drained = 1'b0;
    while (items_sent < limit) begin
      no_idle = ((items_sent / 150) % 4 == 2);
      if (!drained && items_sent > limit / 2) begin
        drain_replies();
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 3))
          send_item(2'($urandom_range(0, 3)), 8'($urandom));
        armed = 1'b0;
      end else begin
        send_frame();
      end
    end
    no_idle = 1'b0;

    // Drop valid, let every result come back, then allow for latency
    @(negedge clk) in_valid <= 1'b0;
    while (pending_replies != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- bisync_reply_frame_receiver_top.f -----
hw/rtl/bsrx_pkg.sv
hw/rtl/bsrx_step.sv
hw/rtl/bisync_reply_frame_receiver_top.sv
sim/bsrx_checker.sv
sim/tb_top.sv
